[rtl/ittf_pkg.sv]
// ============================================================================
// ittf_pkg - shared types and constants for the integer-to-text formatter
// Field widths, flag bit positions, ASCII codes, emit phase codes and the
// command/status structs between controller and datapath.
// ============================================================================
package ittf_pkg;

    // payload widths
    localparam int VALUE_W = 32;
    localparam int RADIX_W = 6;
    localparam int FIELD_W = 6;
    localparam int FLAGS_W = 7;
    localparam int CHAR_W  = 8;

    // valid radix range
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    // format flag bit positions
    localparam int FL_ZEROPAD = 0;
    localparam int FL_SIGNED  = 1;
    localparam int FL_PLUS    = 2;
    localparam int FL_SPACE   = 3;
    localparam int FL_LEFT    = 4;
    localparam int FL_PREFIX  = 5;
    localparam int FL_LOWER   = 6;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

    // long division: quotient bits resolved per cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = VALUE_W / DIV_BITS;
    localparam int DIV_STEP_W = $clog2(DIV_CYCLES);
    localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(DIV_CYCLES - 1);

    // emit phase codes, in output order
    typedef logic [2:0] t_phase;
    localparam t_phase PH_LEAD  = 3'd0;
    localparam t_phase PH_SIGN  = 3'd1;
    localparam t_phase PH_PFX0  = 3'd2;
    localparam t_phase PH_PFX1  = 3'd3;
    localparam t_phase PH_ZPAD  = 3'd4;
    localparam t_phase PH_PREC  = 3'd5;
    localparam t_phase PH_DIG   = 3'd6;
    localparam t_phase PH_TRAIL = 3'd7;

    typedef struct packed {
        logic   load;        // capture a new item
        logic   div_step;    // resolve DIV_BITS quotient bits
        logic   div_write;   // store the finished digit
        logic   size;        // work out padding and total length
        logic   seg_load;    // load segment counter for load_phase
        logic   emit;        // push one text character
        logic   emit_bad;    // push the bad radix marker
        t_phase phase;       // phase of the emitted character
        t_phase load_phase;  // phase whose length is loaded
    } t_cmd;

    typedef struct packed {
        logic in_bad;     // radix on the input is out of range
        logic div_more;   // another digit is needed
        logic seg_zero;   // current segment exhausted
        logic out_free;   // output register can take a character
    } t_status;

    // digit value (below 36) to its character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [5:0] d, input logic lower);
        logic [CHAR_W-1:0] base;
        if (d < 6'd10) begin
            digit_char = CH_ZERO + CHAR_W'(d);
        end else begin
            base = lower ? CH_LO_A : CH_UP_A;
            digit_char = base + CHAR_W'(d - 6'd10);
        end
    endfunction

endpackage

[rtl/ittf_in_if.sv]
// ============================================================================
// ittf_in_if - input item channel
// valid/ready handshake carrying one value and its format settings.
// ============================================================================
interface ittf_in_if;
    import ittf_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic [FIELD_W-1:0] text_width;
    logic [FIELD_W-1:0] min_digits;
    logic [FLAGS_W-1:0] format_flags;

    modport source (output valid, value, radix, text_width, min_digits, format_flags,
                    input ready);
    modport sink   (input valid, value, radix, text_width, min_digits, format_flags,
                    output ready);
endinterface

[rtl/ittf_out_if.sv]
// ============================================================================
// ittf_out_if - output character channel
// valid/ready handshake carrying one character with last and error marks.
// ============================================================================
interface ittf_out_if;
    import ittf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;
    logic              bad_radix;

    modport source (output valid, out_char, last, bad_radix, input ready);
    modport sink   (input valid, out_char, last, bad_radix, output ready);
endinterface

[rtl/ittf_datapath.sv]
// ============================================================================
// ittf_datapath - operand registers, digit divider, digit store, emitter
// Divides by the radix DIV_BITS bits a cycle, keeps digits LSB first and
// builds each output character from the phase the controller names.
// ============================================================================
module ittf_datapath #(
    parameter int MAX_FIELD   = 40,
    parameter int DIGIT_SLOTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ittf_pkg::t_cmd               i_cmd,
    output ittf_pkg::t_status            o_status,
    input  logic [ittf_pkg::VALUE_W-1:0] i_value,
    input  logic [ittf_pkg::RADIX_W-1:0] i_radix,
    input  logic [ittf_pkg::FIELD_W-1:0] i_text_width,
    input  logic [ittf_pkg::FIELD_W-1:0] i_min_digits,
    input  logic [ittf_pkg::FLAGS_W-1:0] i_format_flags,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [ittf_pkg::CHAR_W-1:0]  o_out_char,
    output logic                         o_last,
    output logic                         o_bad_radix
);
    import ittf_pkg::*;

    localparam int MAXV  = (MAX_FIELD > DIGIT_SLOTS) ? MAX_FIELD : DIGIT_SLOTS;
    localparam int SEG_W = $clog2(MAXV + 1);
    localparam int RW    = SEG_W + 2;
    localparam int TW    = $clog2(MAXV + 4);
    localparam int CW    = $clog2(DIGIT_SLOTS + 1);
    localparam int AW    = $clog2(DIGIT_SLOTS);
    localparam logic [FIELD_W-1:0] FIELD_MAX = FIELD_W'(MAX_FIELD);

    // item operands
    logic [RADIX_W-1:0] r_radix;
    logic [VALUE_W-1:0] r_quot;
    logic [5:0]         r_rem;
    logic [CW-1:0]      r_count;
    logic [FIELD_W-1:0] r_width;
    logic [FIELD_W-1:0] r_prec;
    logic               r_zp;
    logic               r_leftj;
    logic               r_lower;
    logic [1:0]         r_pfx_len;
    logic [CHAR_W-1:0]  r_sign_ch;

    // sizing and emit counters
    logic [SEG_W-1:0]   r_pad;
    logic [SEG_W-1:0]   r_pzero;
    logic [TW-1:0]      r_left;
    logic [SEG_W-1:0]   r_seg;
    logic [SEG_W-1:0]   n_seg;

    logic [5:0]         r_store [DIGIT_SLOTS];
    logic [5:0]         r_rd_data;

    logic               r_ov;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               r_bad;

    // ---------------- load decode ----------------
    logic               neg;
    logic [VALUE_W-1:0] abs_val;
    logic [CHAR_W-1:0]  sign_ch;
    logic [1:0]         pfx_len;

    always_comb begin
        neg     = i_format_flags[FL_SIGNED] & i_value[VALUE_W-1];
        abs_val = neg ? (VALUE_W'(0) - i_value) : i_value;
        priority if (neg)                         sign_ch = CH_MINUS;
        else if (i_format_flags[FL_PLUS])         sign_ch = CH_PLUS;
        else if (i_format_flags[FL_SPACE])        sign_ch = CH_SPACE;
        else                                      sign_ch = CH_NUL;
        pfx_len = 2'd0;
        if (i_format_flags[FL_PREFIX]) begin
            if (i_radix == RADIX_HEX)      pfx_len = 2'd2;
            else if (i_radix == RADIX_OCT) pfx_len = 2'd1;
        end
    end

    // ---------------- divider: DIV_BITS restoring steps ----------------
    logic [5:0]         d_rem;
    logic [VALUE_W-1:0] d_quot;

    always_comb begin
        logic [6:0] t;
        d_rem  = r_rem;
        d_quot = r_quot;
        for (int b = 0; b < DIV_BITS; b++) begin
            t      = {d_rem, d_quot[VALUE_W-1]};
            d_quot = {d_quot[VALUE_W-2:0], 1'b0};
            if (t >= {1'b0, r_radix}) begin
                t         = t - {1'b0, r_radix};
                d_quot[0] = 1'b1;
            end
            d_rem = t[5:0];
        end
    end

    // ---------------- sizing ----------------
    logic [SEG_W-1:0]     prec_eff;
    logic signed [RW-1:0] room;
    logic [SEG_W-1:0]     pad;

    always_comb begin
        prec_eff = (SEG_W'(r_count) > SEG_W'(r_prec)) ? SEG_W'(r_count) : SEG_W'(r_prec);
        room     = RW'(r_width) - RW'(r_sign_ch != CH_NUL) - RW'(r_pfx_len) - RW'(prec_eff);
        pad      = (room > 0) ? room[SEG_W-1:0] : '0;
    end

    // ---------------- segment lengths ----------------
    logic [SEG_W-1:0] seg_len;

    always_comb begin
        unique case (i_cmd.load_phase)
            PH_LEAD:  seg_len = (!r_zp && !r_leftj) ? r_pad : '0;
            PH_SIGN:  seg_len = SEG_W'(r_sign_ch != CH_NUL);
            PH_PFX0:  seg_len = SEG_W'(r_pfx_len != 2'd0);
            PH_PFX1:  seg_len = SEG_W'(r_pfx_len == 2'd2);
            PH_ZPAD:  seg_len = r_zp ? r_pad : '0;
            PH_PREC:  seg_len = r_pzero;
            PH_DIG:   seg_len = SEG_W'(r_count);
            PH_TRAIL: seg_len = r_leftj ? r_pad : '0;
            default:  seg_len = '0;
        endcase
    end

    always_comb begin
        priority if (i_cmd.seg_load) n_seg = seg_len;
        else if (i_cmd.emit)         n_seg = r_seg - SEG_W'(1);
        else                         n_seg = r_seg;
    end

    // ---------------- character select ----------------
    logic [CHAR_W-1:0] ch;

    always_comb begin
        unique case (i_cmd.phase)
            PH_LEAD:  ch = CH_SPACE;
            PH_SIGN:  ch = r_sign_ch;
            PH_PFX0:  ch = CH_ZERO;
            PH_PFX1:  ch = r_lower ? CH_LO_X : CH_UP_X;
            PH_ZPAD:  ch = CH_ZERO;
            PH_PREC:  ch = CH_ZERO;
            PH_DIG:   ch = digit_char(r_rd_data, r_lower);
            PH_TRAIL: ch = CH_SPACE;
            default:  ch = CH_SPACE;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_radix   <= i_radix;
            r_quot    <= abs_val;
            r_rem     <= '0;
            r_count   <= '0;
            r_width   <= (i_text_width > FIELD_MAX) ? FIELD_MAX : i_text_width;
            r_prec    <= (i_min_digits > FIELD_MAX) ? FIELD_MAX : i_min_digits;
            r_zp      <= i_format_flags[FL_ZEROPAD] & ~i_format_flags[FL_LEFT];
            r_leftj   <= i_format_flags[FL_LEFT];
            r_lower   <= i_format_flags[FL_LOWER];
            r_pfx_len <= pfx_len;
            r_sign_ch <= sign_ch;
        end else if (i_cmd.div_step) begin
            r_quot <= d_quot;
            if (i_cmd.div_write) begin
                r_rem   <= '0;
                r_count <= r_count + CW'(1);
            end else begin
                r_rem <= d_rem;
            end
        end
        if (i_cmd.size) begin
            r_pad   <= pad;
            r_pzero <= prec_eff - SEG_W'(r_count);
            r_left  <= TW'(pad) + TW'(r_sign_ch != CH_NUL) + TW'(r_pfx_len) + TW'(prec_eff);
        end else if (i_cmd.emit) begin
            r_left <= r_left - TW'(1);
        end
        r_seg <= n_seg;
    end

    // digit store; read address tracks the next segment count
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_write) begin
            r_store[r_count[AW-1:0]] <= d_rem;
        end
        r_rd_data <= r_store[AW'(n_seg - SEG_W'(1))];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_bad) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_bad) begin
            r_char <= CH_NUL;
            r_last <= 1'b1;
            r_bad  <= 1'b1;
        end else if (i_cmd.emit) begin
            r_char <= ch;
            r_last <= (r_left == TW'(1));
            r_bad  <= 1'b0;
        end
    end

    assign o_status.in_bad   = (i_radix < RADIX_MIN) || (i_radix > RADIX_MAX);
    assign o_status.div_more = (d_quot != '0) && ((CW + 1)'(r_count) + (CW + 1)'(1)
                               < (CW + 1)'(DIGIT_SLOTS));
    assign o_status.seg_zero = (r_seg == '0);
    assign o_status.out_free = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_out_char  = r_char;
    assign o_last      = r_last;
    assign o_bad_radix = r_bad;

endmodule

[rtl/ittf_ctrl.sv]
// ============================================================================
// ittf_ctrl - sequencing state machine
// Accepts an item, runs the digit divisions, sizes the text and walks the
// output segments in order; a bad radix gets a single flagged transfer instead.
// ============================================================================
module ittf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ittf_pkg::t_status i_status,
    output ittf_pkg::t_cmd    o_cmd
);
    import ittf_pkg::*;

    // emit states are consecutive and follow phase order
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BAD   = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_SIZE  = 4'd3;
    localparam logic [3:0] S_START = 4'd4;
    localparam logic [3:0] S_LEAD  = 4'd5;
    localparam logic [3:0] S_SIGN  = 4'd6;
    localparam logic [3:0] S_PFX0  = 4'd7;
    localparam logic [3:0] S_PFX1  = 4'd8;
    localparam logic [3:0] S_ZPAD  = 4'd9;
    localparam logic [3:0] S_PREC  = 4'd10;
    localparam logic [3:0] S_DIG   = 4'd11;
    localparam logic [3:0] S_TRAIL = 4'd12;

    logic [3:0]            r_state, n_state;
    logic [DIV_STEP_W-1:0] r_step, n_step;
    t_phase                cur_phase;

    assign cur_phase  = t_phase'(r_state - S_LEAD);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = i_status.in_bad ? S_BAD : S_DIV;
                end
            end
            S_BAD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_bad = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + DIV_STEP_W'(1);
                if (r_step == DIV_LAST) begin
                    o_cmd.div_write = 1'b1;
                    if (!i_status.div_more) n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                o_cmd.size = 1'b1;
                n_state    = S_START;
            end
            S_START: begin
                o_cmd.seg_load   = 1'b1;
                o_cmd.load_phase = PH_LEAD;
                n_state          = S_LEAD;
            end
            S_LEAD, S_SIGN, S_PFX0, S_PFX1, S_ZPAD, S_PREC, S_DIG, S_TRAIL: begin
                o_cmd.phase = cur_phase;
                if (i_status.seg_zero) begin
                    if (r_state == S_TRAIL) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.seg_load   = 1'b1;
                        o_cmd.load_phase = cur_phase + t_phase'(1);
                        n_state          = r_state + 4'd1;
                    end
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

[rtl/integer_to_text_formatter.sv]
// Operation: 32-bit long division by the radix finds the digits, 8 quotient bits
//   a cycle; the text is then sized and the output segments are walked, one
//   character per cycle within a segment while the output register can take one.
// Throughput: one item at a time; the next item is taken once the sequencer is
//   idle again, after the last character is in the output register.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ============================================================================
// integer_to_text_formatter - printf-style integer to ASCII text
// Formats a 32-bit value in radix 2..36 with width, minimum digits and flags,
// one character per output transfer, last marked.
// ============================================================================
module integer_to_text_formatter #(
    parameter int MAX_FIELD   = 40,   // width / min digits saturate here
    parameter int DIGIT_SLOTS = 32    // digits kept (least significant)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ittf_in_if.sink     i_item,
    ittf_out_if.source  o_char
);
    import ittf_pkg::*;

    // command / status bus between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // Sequencer: idle -> divide -> size -> emit segments
    // (lead spaces, sign, prefix, zero pad, precision zeros, digits, trail
    // spaces). A bad radix skips straight to a single flagged transfer.
    ittf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: operands, divider, digit store and the output register, which
    // holds a character while the sink stalls.
    ittf_datapath #(
        .MAX_FIELD   (MAX_FIELD),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_value        (i_item.value),
        .i_radix        (i_item.radix),
        .i_text_width   (i_item.text_width),
        .i_min_digits   (i_item.min_digits),
        .i_format_flags (i_item.format_flags),
        .i_out_ready    (o_char.ready),
        .o_out_valid    (o_char.valid),
        .o_out_char     (o_char.out_char),
        .o_last         (o_char.last),
        .o_bad_radix    (o_char.bad_radix)
    );

    // ---------------- checks ----------------
    // busy right after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("input ready right after a transfer");

    // bad radix marker is a lone NUL that ends the item
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char.valid && o_char.bad_radix |-> o_char.last && (o_char.out_char == CH_NUL))
        else $error("bad radix result malformed");

    // text transfers never carry NUL
    a_text_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char.valid && !o_char.bad_radix |-> (o_char.out_char != CH_NUL))
        else $error("NUL in text output");

endmodule

[dv/integer_to_text_formatter_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// integer_to_text_formatter_test - self-checking bench for the text formatter
// Drives value/format items through the input channel and checks every output
// character against typed text or an in-bench formatter. A directed table covers the
// extremes, the flag interactions and bad radix codes; random items follow
// under four idle/stall regimes on both channels.
// ============================================================================
module integer_to_text_formatter_test;
    import ittf_pkg::*;

    localparam int MAX_FIELD    = 40;
    localparam int DIGIT_SLOTS  = 32;
    localparam int RANDOM_ITEMS = 448;
    localparam int DRAIN_CYCLES = 250;        // outlasts the slowest item
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PRINT_CAP    = 40;

    // flag masks built from the package bit positions
    localparam logic [FLAGS_W-1:0] F_ZPAD   = FLAGS_W'(1 << FL_ZEROPAD);
    localparam logic [FLAGS_W-1:0] F_SIGNED = FLAGS_W'(1 << FL_SIGNED);
    localparam logic [FLAGS_W-1:0] F_PLUS   = FLAGS_W'(1 << FL_PLUS);
    localparam logic [FLAGS_W-1:0] F_SPACE  = FLAGS_W'(1 << FL_SPACE);
    localparam logic [FLAGS_W-1:0] F_LEFT   = FLAGS_W'(1 << FL_LEFT);
    localparam logic [FLAGS_W-1:0] F_PFX    = FLAGS_W'(1 << FL_PREFIX);
    localparam logic [FLAGS_W-1:0] F_LOWER  = FLAGS_W'(1 << FL_LOWER);
    localparam logic [FLAGS_W-1:0] F_ALL    = '1;

    localparam string DIGITS_UP = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string DIGITS_LO = "0123456789abcdefghijklmnopqrstuvwxyz";

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic [FIELD_W-1:0] text_width;
        logic [FIELD_W-1:0] min_digits;
        logic [FLAGS_W-1:0] format_flags;
    } t_fmt_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
        logic              bad_radix;
    } t_text_char;

    typedef logic [CHAR_W-1:0] t_char_q [$];

    // how a directed row gets its expectation
    typedef enum logic [1:0] {ROW_PREDICT, ROW_TEXT, ROW_BAD} t_row_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ittf_in_if  item_if ();
    ittf_out_if char_if ();

    integer_to_text_formatter #(
        .MAX_FIELD   (MAX_FIELD),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_char  (char_if)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_text_char pending_chars [$];   // characters still owed by the block
    int         mismatch_count = 0;
    int         chars_seen     = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 0;  // chance per cycle that the sender holds off
    int         recv_stall_pct = 0;  // chance per cycle that the sink drops ready

    // directed table
    t_fmt_item  dir_items [$];
    t_row_kind  dir_kinds [$];
    string      dir_texts [$];

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic add_row(input logic [VALUE_W-1:0] v, input logic [RADIX_W-1:0] r,
                           input logic [FIELD_W-1:0] w, input logic [FIELD_W-1:0] p,
                           input logic [FLAGS_W-1:0] f, input t_row_kind kind,
                           input string text);
        dir_items.push_back('{value: v, radix: r, text_width: w, min_digits: p,
                              format_flags: f});
        dir_kinds.push_back(kind);
        dir_texts.push_back(text);
    endtask

    // append one formatted value, last set on its final character
    function automatic void queue_text(input t_char_q text);
        for (int k = 0; k < text.size(); k++)
            pending_chars.push_back('{out_char: text[k], last: (k == text.size() - 1),
                                      bad_radix: 1'b0});
    endfunction

    function automatic void queue_bad_radix();
        pending_chars.push_back('{out_char: CH_NUL, last: 1'b1, bad_radix: 1'b1});
    endfunction

    // printf-style formatting of one item into the expected characters
    function automatic void format_integer(input t_fmt_item it);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] quo;
        logic [5:0]         digit_buf [DIGIT_SLOTS];
        logic [FLAGS_W-1:0] fl;
        logic [CHAR_W-1:0]  sign_ch;
        t_char_q            text;
        string              set;
        int                 width, prec, ndig, pfx_len, pad;
        if (it.radix < RADIX_MIN || it.radix > RADIX_MAX) begin
            queue_bad_radix();
            return;
        end
        width = (it.text_width > MAX_FIELD) ? MAX_FIELD : int'(it.text_width);
        prec  = (it.min_digits > MAX_FIELD) ? MAX_FIELD : int'(it.min_digits);
        fl = it.format_flags;
        if (fl[FL_LEFT])
            fl[FL_ZEROPAD] = 1'b0;          // left justify beats zero pad
        set = fl[FL_LOWER] ? DIGITS_LO : DIGITS_UP;

        mag = it.value;
        sign_ch = CH_NUL;
        if (fl[FL_SIGNED] && mag[VALUE_W-1]) begin
            sign_ch = CH_MINUS;
            mag = -mag;                     // 0x80000000 stays, read as unsigned
        end else if (fl[FL_PLUS]) begin
            sign_ch = CH_PLUS;
        end else if (fl[FL_SPACE]) begin
            sign_ch = CH_SPACE;
        end
        pfx_len = 0;
        if (fl[FL_PREFIX]) begin
            if (it.radix == RADIX_HEX)
                pfx_len = 2;
            else if (it.radix == RADIX_OCT)
                pfx_len = 1;
        end

        // digits, least significant first; store caps the count
        quo = mag;
        ndig = 0;
        do begin
            digit_buf[ndig] = 6'(quo % VALUE_W'(it.radix));
            quo = quo / VALUE_W'(it.radix);
            ndig++;
        end while (quo != 0 && ndig < DIGIT_SLOTS);

        if (ndig > prec)
            prec = ndig;
        pad = width - ((sign_ch != CH_NUL) ? 1 : 0) - pfx_len - prec;
        if (pad < 0)
            pad = 0;

        if (!fl[FL_ZEROPAD] && !fl[FL_LEFT])
            repeat (pad) text.push_back(CH_SPACE);
        if (sign_ch != CH_NUL)
            text.push_back(sign_ch);
        if (pfx_len >= 1)
            text.push_back(CH_ZERO);
        if (pfx_len == 2)
            text.push_back(fl[FL_LOWER] ? CH_LO_X : CH_UP_X);
        if (fl[FL_ZEROPAD])
            repeat (pad) text.push_back(CH_ZERO);
        repeat (prec - ndig) text.push_back(CH_ZERO);
        for (int k = ndig - 1; k >= 0; k--)
            text.push_back(set[digit_buf[k]]);
        if (fl[FL_LEFT])
            repeat (pad) text.push_back(CH_SPACE);
        queue_text(text);
    endfunction

    // random item: mostly valid radixes, common bases favored, small fields
    function automatic t_fmt_item random_item();
        t_fmt_item it;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 8)
            it.radix = $urandom_range(1) ? RADIX_W'($urandom_range(37, 63))
                                         : RADIX_W'($urandom_range(0, 1));
        else if (pick < 45)
            case ($urandom_range(4))
                0: it.radix = RADIX_MIN;
                1: it.radix = RADIX_OCT;
                2: it.radix = 6'd10;
                3: it.radix = RADIX_HEX;
                default: it.radix = RADIX_MAX;
            endcase
        else
            it.radix = RADIX_W'($urandom_range(2, 36));

        case ($urandom_range(3))
            0: it.value = VALUE_W'($urandom_range(0, 999));
            1: it.value = -VALUE_W'($urandom_range(1, 1000));
            2: it.value = $urandom;
            default:
                case ($urandom_range(4))
                    0: it.value = '0;
                    1: it.value = 32'h0000_0001;
                    2: it.value = 32'h7FFF_FFFF;
                    3: it.value = 32'h8000_0000;
                    default: it.value = '1;
                endcase
        endcase

        it.text_width  = ($urandom_range(3) == 0) ? FIELD_W'($urandom_range(0, 63))
                                                  : FIELD_W'($urandom_range(0, 12));
        it.min_digits  = ($urandom_range(3) == 0) ? FIELD_W'($urandom_range(0, 63))
                                                  : FIELD_W'($urandom_range(0, 8));
        it.format_flags = FLAGS_W'($urandom_range(0, 127));
        return it;
    endfunction

    // one input transfer; returns at the edge where it is taken
    task automatic send_item(input t_fmt_item it);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        item_if.valid        <= 1'b1;
        item_if.value        <= it.value;
        item_if.radix        <= it.radix;
        item_if.text_width   <= it.text_width;
        item_if.min_digits   <= it.min_digits;
        item_if.format_flags <= it.format_flags;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    // output side: check each character transfer, then pick ready for the next
    // cycle. Signals are read right after the edge, so they hold pre-edge values.
    always @(posedge i_clk) begin : char_sink
        t_text_char want;
        if (i_rst_n && char_if.valid && char_if.ready) begin
            chars_seen++;
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("char #%0d 0x%02h arrived with nothing pending",
                                          chars_seen, char_if.out_char));
            end else begin
                want = pending_chars.pop_front();
                if (char_if.out_char !== want.out_char)
                    report_mismatch($sformatf("char #%0d out_char 0x%02h, want 0x%02h",
                                              chars_seen, char_if.out_char, want.out_char));
                if (char_if.last !== want.last)
                    report_mismatch($sformatf("char #%0d last %b, want %b",
                                              chars_seen, char_if.last, want.last));
                if (char_if.bad_radix !== want.bad_radix)
                    report_mismatch($sformatf("char #%0d bad_radix %b, want %b",
                                              chars_seen, char_if.bad_radix,
                                              want.bad_radix));
            end
        end
        char_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d chars still pending",
                 cycle_count, pending_chars.size());
        $display("[integer_to_text_formatter] ERROR");
        $finish;
    end

    initial begin
        t_fmt_item item;
        t_char_q   text;
        int        send_pct [4];
        int        recv_pct [4];

        i_rst_n              = 1'b0;
        item_if.valid        = 1'b0;
        item_if.value        = '0;
        item_if.radix        = '0;
        item_if.text_width   = '0;
        item_if.min_digits   = '0;
        item_if.format_flags = '0;
        char_if.ready        = 1'b0;

        // idle regimes: none, sender gaps, sink stalls, light mix on both
        send_pct = '{0, 87, 0, 16};
        recv_pct = '{0, 0, 87, 16};

        // value, radix, width, min digits, flags, how checked, typed text
        add_row(32'd0,         6'd10, 6'd0,  6'd0,  '0, ROW_TEXT, "0");
        add_row(32'hFFFF_FFFF, 6'd0,  6'd63, 6'd63, F_ALL, ROW_BAD, "");
        add_row(32'd12,        6'd1,  6'd0,  6'd0,  '0, ROW_BAD, "");
        add_row(32'd12,        6'd37, 6'd5,  6'd0,  F_PFX, ROW_BAD, "");
        add_row(32'd0,         6'd63, 6'd0,  6'd0,  '0, ROW_BAD, "");
        // radix 2 fills the whole digit store
        add_row(32'hFFFF_FFFF, 6'd2,  6'd0,  6'd0,  '0, ROW_TEXT,
                "11111111111111111111111111111111");
        add_row(32'hFFFF_FFFF, 6'd10, 6'd0,  6'd0,  '0, ROW_TEXT, "4294967295");
        add_row(32'hFFFF_FFFF, 6'd36, 6'd0,  6'd0,  F_LOWER, ROW_PREDICT, "");
        // most negative value keeps its magnitude
        add_row(32'h8000_0000, 6'd10, 6'd0,  6'd0,  F_SIGNED, ROW_TEXT, "-2147483648");
        add_row(32'hFFFF_FFFF, 6'd10, 6'd0,  6'd0,  F_SIGNED, ROW_TEXT, "-1");
        add_row(32'h7FFF_FFFF, 6'd10, 6'd0,  6'd0,  F_SIGNED | F_PLUS, ROW_TEXT,
                "+2147483647");
        add_row(32'd5,         6'd10, 6'd0,  6'd0,  F_PLUS | F_SPACE, ROW_TEXT, "+5");
        add_row(32'd5,         6'd10, 6'd0,  6'd0,  F_SPACE, ROW_TEXT, " 5");
        add_row(32'd255,       6'd16, 6'd0,  6'd0,  F_PFX, ROW_TEXT, "0XFF");
        add_row(32'd255,       6'd16, 6'd0,  6'd0,  F_PFX | F_LOWER, ROW_TEXT, "0xff");
        add_row(32'd8,         6'd8,  6'd0,  6'd0,  F_PFX, ROW_TEXT, "010");
        // prefix shows on zero too
        add_row(32'd0,         6'd16, 6'd0,  6'd0,  F_PFX, ROW_TEXT, "0X0");
        add_row(32'd0,         6'd8,  6'd0,  6'd0,  F_PFX, ROW_PREDICT, "");
        add_row(32'd42,        6'd10, 6'd6,  6'd0,  F_ZPAD, ROW_TEXT, "000042");
        add_row(32'd42,        6'd10, 6'd6,  6'd0,  F_ZPAD | F_LEFT, ROW_TEXT, "42    ");
        add_row(32'd42,        6'd10, 6'd6,  6'd0,  '0, ROW_TEXT, "    42");
        add_row(32'd12345,     6'd10, 6'd2,  6'd0,  '0, ROW_TEXT, "12345");
        add_row(32'd0,         6'd10, 6'd0,  6'd5,  '0, ROW_TEXT, "00000");
        add_row(32'd7,         6'd10, 6'd5,  6'd3,  F_PLUS, ROW_TEXT, " +007");
        // width and min digits saturate: longest possible text
        add_row(32'd42,        6'd16, 6'd63, 6'd63, F_SIGNED | F_PLUS | F_PFX,
                ROW_PREDICT, "");
        add_row(32'hDEAD_BEEF, 6'd16, 6'd20, 6'd10, F_ALL, ROW_PREDICT, "");
        add_row(32'hFFFF_FFD6, 6'd16, 6'd12, 6'd0,  F_SIGNED | F_ZPAD | F_PFX,
                ROW_PREDICT, "");
        add_row(32'h0000_1234, 6'd8,  6'd63, 6'd0,  F_PFX | F_LEFT, ROW_PREDICT, "");

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, no idling
        for (int row = 0; row < dir_items.size(); row++) begin
            send_item(dir_items[row]);
            case (dir_kinds[row])
                ROW_BAD: queue_bad_radix();
                ROW_TEXT: begin
                    text.delete();
                    for (int k = 0; k < dir_texts[row].len(); k++)
                        text.push_back(dir_texts[row][k]);
                    queue_text(text);
                end
                default: format_integer(dir_items[row]);
            endcase
        end

        // random items, a quarter under each idle regime
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % (RANDOM_ITEMS / 4) == 0) begin
                send_idle_pct  = send_pct[n / (RANDOM_ITEMS / 4)];
                recv_stall_pct = recv_pct[n / (RANDOM_ITEMS / 4)];
            end
            item = random_item();
            send_item(item);
            format_integer(item);
        end
        item_if.valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge i_clk);
        // anything the block emits now is unexpected and gets flagged by the sink
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("[integer_to_text_formatter] OK");
        else
            $display("[integer_to_text_formatter] ERROR");
        $finish;
    end

endmodule
